// ===== src/fdsd_pkg.sv =====
// Shared types, constants and the delta table of the Fibonacci-delta sample decoder.
package fdsd_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int GAIN_W    = 32;
    localparam int SCALED_W  = 40;
    localparam int CFG_IDX_W = 8;
    localparam int NIBBLE_W  = 4;

    // Queue between the front and back parts.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = CFG_IDX_W'(1);

    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic MODE_RAW   = 1'b0;
    localparam logic MODE_DELTA = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(65536);

    typedef struct packed {
        logic              mode;
        logic [GAIN_W-1:0] gain;
    } t_cfg;

    // One queued byte: one sample in raw mode, two in delta mode.
    typedef struct packed {
        logic [SAMPLE_W-1:0] s0;
        logic [SAMPLE_W-1:0] s1;
        logic                two;
    } t_entry;

    // Signed Fibonacci delta for a 4-bit code, in two's complement.
    function automatic logic [SAMPLE_W-1:0] delta_of(input logic [NIBBLE_W-1:0] code);
        logic [SAMPLE_W-1:0] d;
        case (code)
            4'd0:    d = 8'hDE;  // -34
            4'd1:    d = 8'hEB;  // -21
            4'd2:    d = 8'hF3;  // -13
            4'd3:    d = 8'hF8;  // -8
            4'd4:    d = 8'hFB;  // -5
            4'd5:    d = 8'hFD;  // -3
            4'd6:    d = 8'hFE;  // -2
            4'd7:    d = 8'hFF;  // -1
            4'd8:    d = 8'h00;
            4'd9:    d = 8'h01;
            4'd10:   d = 8'h02;
            4'd11:   d = 8'h03;
            4'd12:   d = 8'h05;
            4'd13:   d = 8'h08;
            4'd14:   d = 8'h0D;
            4'd15:   d = 8'h15;
            default: d = 8'h00;
        endcase
        return d;
    endfunction

endpackage

// ===== src/fdsd_channels.sv =====
// Valid/ready channel interfaces for input items, result items and register writes.
interface fdsd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [fdsd_pkg::SAMPLE_W-1:0] data_byte;

    modport source (output valid, op, data_byte, input ready);
    modport sink   (input valid, op, data_byte, output ready);
endinterface

interface fdsd_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fdsd_pkg::SCALED_W-1:0] scaled_sample;
    logic signed [fdsd_pkg::SAMPLE_W-1:0] raw_sample;
    logic                                 last_of_run;

    modport source (output valid, scaled_sample, raw_sample, last_of_run, input ready);
    modport sink   (input valid, scaled_sample, raw_sample, last_of_run, output ready);
endinterface

interface fdsd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fdsd_pkg::CFG_IDX_W-1:0] index;
    logic [fdsd_pkg::GAIN_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/fdsd_front.sv =====
// Front part: accepts items, handles restarts and decodes bytes into samples.
module fdsd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fdsd_in_if.sink            i_in,
    input  fdsd_pkg::t_cfg     i_cfg,
    output logic               o_push,
    output fdsd_pkg::t_entry   o_entry,
    input  logic               i_push_ready
);

    logic [fdsd_pkg::SAMPLE_W-1:0] r_acc;
    logic [fdsd_pkg::SAMPLE_W-1:0] n_acc;
    logic [fdsd_pkg::SAMPLE_W-1:0] hi_sum;
    logic [fdsd_pkg::SAMPLE_W-1:0] lo_sum;
    logic                          accept;

    assign i_in.ready = i_push_ready;
    assign accept     = i_in.valid && i_push_ready;

    // Both nibble steps are chained here, so the queue holds finished samples.
    assign hi_sum = r_acc + fdsd_pkg::delta_of(i_in.data_byte[7:4]);
    assign lo_sum = hi_sum + fdsd_pkg::delta_of(i_in.data_byte[3:0]);

    always_comb begin
        o_push = i_in.valid && (i_in.op == fdsd_pkg::OP_DATA);
        n_acc  = r_acc;
        if (i_cfg.mode == fdsd_pkg::MODE_DELTA) begin
            o_entry.s0  = hi_sum;
            o_entry.s1  = lo_sum;
            o_entry.two = 1'b1;
        end else begin
            o_entry.s0  = i_in.data_byte;
            o_entry.s1  = i_in.data_byte;
            o_entry.two = 1'b0;
        end
        if (accept) begin
            if (i_in.op == fdsd_pkg::OP_RESTART) begin
                n_acc = '0;
            end else if (i_cfg.mode == fdsd_pkg::MODE_DELTA) begin
                n_acc = lo_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

endmodule

// ===== src/fdsd_queue.sv =====
// Short queue of decoded entries between the front and back parts.
module fdsd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fdsd_pkg::t_entry i_entry,
    output logic             o_push_ready,
    output logic             o_valid,
    output fdsd_pkg::t_entry o_head,
    input  logic             i_pop
);

    fdsd_pkg::t_entry                r_mem [fdsd_pkg::QDEPTH];
    logic [fdsd_pkg::QPTR_W-1:0]     r_wptr;
    logic [fdsd_pkg::QPTR_W-1:0]     r_rptr;
    logic [fdsd_pkg::QCNT_W-1:0]     r_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_push_ready = (r_count != fdsd_pkg::QCNT_W'(fdsd_pkg::QDEPTH));
    assign o_valid      = (r_count != '0);
    assign o_head       = r_mem[r_rptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    function automatic logic [fdsd_pkg::QPTR_W-1:0] next_ptr(
        input logic [fdsd_pkg::QPTR_W-1:0] p);
        logic [fdsd_pkg::QPTR_W-1:0] r;
        if (p == fdsd_pkg::QPTR_W'(fdsd_pkg::QDEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= next_ptr(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= next_ptr(r_rptr);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= fdsd_pkg::QCNT_W'(fdsd_pkg::QDEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == fdsd_pkg::QCNT_W'(fdsd_pkg::QDEPTH))
        |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== src/fdsd_back.sv =====
// Back part: walks the samples of each queued entry and applies the volume.
module fdsd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  fdsd_pkg::t_entry i_head,
    output logic             o_pop,
    input  fdsd_pkg::t_cfg   i_cfg,
    fdsd_out_if.source       o_out
);

    logic                                 r_sub;
    logic                                 r_valid;
    logic signed [fdsd_pkg::SCALED_W-1:0] r_scaled;
    logic [fdsd_pkg::SAMPLE_W-1:0]        r_raw;
    logic                                 r_last;
    logic                                 load;
    logic                                 emit;
    logic                                 last;
    logic [fdsd_pkg::SAMPLE_W-1:0]        sample;
    logic signed [fdsd_pkg::SCALED_W:0]   prod;

    localparam int EXT_W = fdsd_pkg::SCALED_W + 1;

    assign load   = !r_valid || o_out.ready;
    assign emit   = load && i_valid;
    // The first sample of a delta entry leaves the entry in the queue.
    assign last   = !i_head.two || r_sub;
    assign o_pop  = emit && last;
    assign sample = r_sub ? i_head.s1 : i_head.s0;
    assign prod   = $signed({{(EXT_W - fdsd_pkg::SAMPLE_W){sample[fdsd_pkg::SAMPLE_W-1]}}, sample})
                  * $signed({{(EXT_W - fdsd_pkg::GAIN_W){1'b0}}, i_cfg.gain});

    assign o_out.valid         = r_valid;
    assign o_out.scaled_sample = r_scaled;
    assign o_out.raw_sample    = $signed(r_raw);
    assign o_out.last_of_run   = r_last;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_scaled <= prod[fdsd_pkg::SCALED_W-1:0];
            r_raw    <= sample;
            r_last   <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= i_valid;
            end
            if (emit) begin
                r_sub <= !last;
            end
        end
    end

`ifndef SYNTHESIS
    a_sub_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (i_valid && i_head.two))
        else $error("second sample pending without a delta entry");
    a_first_holds_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> r_sub)
        else $error("first sample shown but its entry was released");
`endif

endmodule

// ===== src/fib_delta_sample_decoder.sv =====
// Top level of the Fibonacci-delta sample decoder: registers, front, queue and back.
// Each input item is a body byte or a restart. A restart clears the delta accumulator and
// yields no result. In raw mode a byte yields one signed sample; in delta mode its high and
// then low nibble each add a Fibonacci delta to the accumulator, yielding two samples. Every
// sample leaves with its product by the 16.16 volume (exact, 40 bits signed). The front decodes
// a byte combinationally and a two-entry queue feeds the back, which emits one result per cycle
// while the output is ready, from the single output register of the back part. An accepted byte
// is registered in the queue and then, sample by sample, in that output register of the back part.
// Register writes are always accepted and should be made while the block is idle.
module fib_delta_sample_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fdsd_in_if.sink    i_in,
    fdsd_out_if.source o_out,
    fdsd_cfg_if.sink   i_cfg
);

    fdsd_pkg::t_cfg   r_cfg;
    fdsd_pkg::t_entry push_entry;
    fdsd_pkg::t_entry head;
    logic             push;
    logic             push_ready;
    logic             q_valid;
    logic             pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= fdsd_pkg::MODE_RAW;
            r_cfg.gain <= fdsd_pkg::GAIN_UNITY;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                fdsd_pkg::CFG_MODE: r_cfg.mode <= i_cfg.data[0];
                fdsd_pkg::CFG_GAIN: r_cfg.gain <= i_cfg.data;
                default:            r_cfg      <= r_cfg;
            endcase
        end
    end

    fdsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (r_cfg),
        .o_push       (push),
        .o_entry      (push_entry),
        .i_push_ready (push_ready)
    );

    fdsd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (push_entry),
        .o_push_ready (push_ready),
        .o_valid      (q_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    fdsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_head  (head),
        .o_pop   (pop),
        .i_cfg   (r_cfg),
        .o_out   (o_out)
    );

endmodule

// ===== sim/fdsd_sample_checker.sv =====
// Scoreboard for the Fibonacci-delta sample decoder: predicts samples and compares results.
module fdsd_sample_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    fdsd_in_if   i_in,
    fdsd_out_if  i_out,
    fdsd_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic signed [fdsd_pkg::SCALED_W-1:0] scaled;
        logic signed [fdsd_pkg::SAMPLE_W-1:0] raw;
        logic                                 last;
    } t_sample;

    t_sample                       samples_due[$];
    logic                          mode_q;
    logic [fdsd_pkg::GAIN_W-1:0]   gain_q;
    logic [fdsd_pkg::SAMPLE_W-1:0] acc_q;
    int                            fails;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fails        = 0;
        mode_q       = fdsd_pkg::MODE_RAW;
        gain_q       = fdsd_pkg::GAIN_UNITY;
        acc_q        = '0;
    end

    function automatic logic [fdsd_pkg::SAMPLE_W-1:0] fib_step(
        input logic [fdsd_pkg::NIBBLE_W-1:0] code);
        logic [fdsd_pkg::SAMPLE_W-1:0] d;
        case (code)
            4'd0:    d = 8'(-34);
            4'd1:    d = 8'(-21);
            4'd2:    d = 8'(-13);
            4'd3:    d = 8'(-8);
            4'd4:    d = 8'(-5);
            4'd5:    d = 8'(-3);
            4'd6:    d = 8'(-2);
            4'd7:    d = 8'(-1);
            4'd8:    d = 8'(0);
            4'd9:    d = 8'(1);
            4'd10:   d = 8'(2);
            4'd11:   d = 8'(3);
            4'd12:   d = 8'(5);
            4'd13:   d = 8'(8);
            4'd14:   d = 8'(13);
            default: d = 8'(21);
        endcase
        return d;
    endfunction

    // The product of a signed byte and an unsigned 32-bit gain always fits in 40 bits.
    function automatic t_sample scaled_sample(input logic [fdsd_pkg::SAMPLE_W-1:0] s,
                                              input logic last);
        t_sample r;
        longint  prod;
        prod     = longint'($signed(s)) * longint'(gain_q);
        r.scaled = prod[fdsd_pkg::SCALED_W-1:0];
        r.raw    = s;
        r.last   = last;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sample got;
        t_sample want;
        if (!i_rst_n) begin
            samples_due.delete();
            mode_q = fdsd_pkg::MODE_RAW;
            gain_q = fdsd_pkg::GAIN_UNITY;
            acc_q  = '0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.scaled_sample, i_out.raw_sample, i_out.last_of_run};
                if (samples_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected sample: scaled %0d raw %0d last %0b",
                                 got.scaled, got.raw, got.last);
                end else begin
                    want = samples_due.pop_front();
                    if (got.scaled !== want.scaled || got.raw !== want.raw ||
                        got.last !== want.last) begin
                        fails++;
                        if (fails <= 10)
                            $display("sample mismatch: expected scaled %0d raw %0d last %0b, %s",
                                     want.scaled, want.raw, want.last,
                                     $sformatf("got scaled %0d raw %0d last %0b",
                                               got.scaled, got.raw, got.last));
                    end
                end
            end

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    fdsd_pkg::CFG_MODE: mode_q = i_cfg.data[0];
                    fdsd_pkg::CFG_GAIN: gain_q = i_cfg.data;
                    default: ;
                endcase
            end

            if (i_in.valid && i_in.ready) begin
                if (i_in.op == fdsd_pkg::OP_RESTART) begin
                    acc_q = '0;
                end else if (mode_q == fdsd_pkg::MODE_RAW) begin
                    samples_due.push_back(scaled_sample(i_in.data_byte, 1'b1));
                end else begin
                    // High nibble first; the accumulator wraps without saturation.
                    acc_q = acc_q + fib_step(i_in.data_byte[7:4]);
                    samples_due.push_back(scaled_sample(acc_q, 1'b0));
                    acc_q = acc_q + fib_step(i_in.data_byte[3:0]);
                    samples_due.push_back(scaled_sample(acc_q, 1'b1));
                end
            end
        end
        o_pending    <= samples_due.size();
        o_fail_count <= fails;
    end

endmodule

// ===== sim/tb_fib_delta_sample_decoder.sv =====
// Testbench top for the Fibonacci-delta sample decoder: clock, reset, stimulus and verdict.
module tb_fib_delta_sample_decoder;

    localparam int QUIET_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 120;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 91;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   quiet_cycles = 0;
    int   in_calm = 0;
    int   out_calm = 0;
    int   results_taken = 0;

    fdsd_in_if  in_ch ();
    fdsd_out_if out_ch ();
    fdsd_cfg_if cfg_ch ();

    fib_delta_sample_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    fdsd_sample_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Mostly random gaps, with occasional runs of back-to-back items.
    function automatic int idle_draw(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // Returns in the time step of the handshake; the next call decides what valid does next.
    task automatic send_item(input logic op, input logic [fdsd_pkg::SAMPLE_W-1:0] b);
        int gap;
        gap = idle_draw(in_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.data_byte <= b;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
    endtask

    task automatic drain();
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Registers change only once the block has gone quiet.
    task automatic new_phase(input logic mode, input logic [fdsd_pkg::GAIN_W-1:0] gain);
        in_ch.valid <= 1'b0;
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= fdsd_pkg::CFG_MODE;
        cfg_ch.data  <= fdsd_pkg::GAIN_W'(mode);
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.index <= fdsd_pkg::CFG_GAIN;
        cfg_ch.data  <= gain;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        logic                        mode;
        logic [fdsd_pkg::GAIN_W-1:0] gain;
        in_ch.valid     <= 1'b0;
        in_ch.op        <= fdsd_pkg::OP_DATA;
        in_ch.data_byte <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= fdsd_pkg::CFG_MODE;
        cfg_ch.data     <= '0;
        do @(posedge i_clk); while (!i_rst_n);

        // Raw mode at the reset settings: byte extremes and a restart.
        send_item(fdsd_pkg::OP_DATA, 8'h00);
        send_item(fdsd_pkg::OP_DATA, 8'h7F);
        send_item(fdsd_pkg::OP_DATA, 8'h80);
        send_item(fdsd_pkg::OP_DATA, 8'hFF);
        send_item(fdsd_pkg::OP_DATA, 8'h01);
        send_item(fdsd_pkg::OP_RESTART, 8'hA5);

        // Delta mode at full gain: repeated largest steps push the accumulator around.
        new_phase(fdsd_pkg::MODE_DELTA, '1);
        repeat (7) send_item(fdsd_pkg::OP_DATA, 8'hFF);
        repeat (3) send_item(fdsd_pkg::OP_DATA, 8'h00);
        send_item(fdsd_pkg::OP_DATA, 8'h8F);
        send_item(fdsd_pkg::OP_DATA, 8'hF8);
        send_item(fdsd_pkg::OP_RESTART, 8'h00);
        send_item(fdsd_pkg::OP_DATA, 8'h5A);

        // Switch to raw and back; the accumulator must survive the detour.
        new_phase(fdsd_pkg::MODE_RAW, '0);
        send_item(fdsd_pkg::OP_DATA, 8'h80);
        send_item(fdsd_pkg::OP_DATA, 8'h7F);
        new_phase(fdsd_pkg::MODE_DELTA, fdsd_pkg::GAIN_UNITY);
        send_item(fdsd_pkg::OP_DATA, 8'h08);
        send_item(fdsd_pkg::OP_DATA, 8'h3C);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       gain = fdsd_pkg::GAIN_UNITY;
                1:       gain = '1;
                2:       gain = '0;
                3:       gain = 32'h8000_0000;
                4:       gain = 32'd1;
                default: gain = $urandom();
            endcase
            mode = (ph % 3 == 0) ? fdsd_pkg::MODE_RAW : fdsd_pkg::MODE_DELTA;
            new_phase(mode, gain);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 15) == 0)
                    send_item(fdsd_pkg::OP_RESTART, 8'($urandom()));
                else
                    send_item(fdsd_pkg::OP_DATA, 8'($urandom()));
            end
        end

        in_ch.valid <= 1'b0;
        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("fib_delta_sample_decoder regression: pass");
        else
            $display("fib_delta_sample_decoder regression: fail");
        $finish;
    end

    // Sample receiver; twice it holds off long enough for the block to back up.
    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (results_taken == 200 || results_taken == 700)
                gap = HOLD_CYCLES;
            else
                gap = idle_draw(out_calm);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            results_taken++;
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("fib_delta_sample_decoder regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ===== filelist.f =====
src/fdsd_pkg.sv
src/fdsd_channels.sv
src/fdsd_front.sv
src/fdsd_queue.sv
src/fdsd_back.sv
src/fib_delta_sample_decoder.sv
sim/fdsd_sample_checker.sv
sim/tb_fib_delta_sample_decoder.sv
